@@ sv/rlc_pkg.sv @@
package rlc_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CEL_WIDTH   = 2'd0,
    REG_CEL_HEIGHT  = 2'd1,
    REG_TRANSPARENT = 2'd2,
    REG_MIRROR      = 2'd3
  } cfg_reg_t;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned VCNT_W   = 5;

  // Run position saturates here
  localparam logic [POS_W-1:0] POS_MAX = 9'd511;

endpackage

@@ sv/rlc_ifs.sv @@
interface rlc_chunk_if;
  import rlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] chunk_byte;

  modport source (output valid, output chunk_byte, input ready);
  modport sink   (input valid, input chunk_byte, output ready);
endinterface

interface rlc_pixel_if;
  import rlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pixel_word;
  logic [VCNT_W-1:0] pixel_valid_count;
  logic [ROW_W-1:0]  row_number;
  logic              row_last_word;
  logic              cel_last_row;
  logic              row_overflow;

  modport source (output valid, output pixel_word, output pixel_valid_count,
                  output row_number, output row_last_word, output cel_last_row,
                  output row_overflow, input ready);
  modport sink   (input valid, input pixel_word, input pixel_valid_count,
                  input row_number, input row_last_word, input cel_last_row,
                  input row_overflow, output ready);
endinterface

@@ sv/run_length_cel_decoder_unit.sv @@
// Run-length cel row decoder.
// Input channel "chunk" carries one run byte per request: color in bits 7..4,
// count in bits 3..0; the byte writes count*2 pixels into the row store from
// the left edge, or from the right edge when mirror_enable is set. A zero
// byte ends the row and the row goes out on channel "pixels" as words of
// PIXELS_PER_WORD 4-bit pixels, tagged with the row number and the last-word,
// last-row and overflow flags; the row store then reads as transparent again.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them while the block is idle, left unchecked by the block.
// A run byte reads each store word it touches and writes it back merged with
// the run color, reading the next word as it writes; a byte that writes no
// pixel returns straight to idle. A zero byte walks the row's words, each
// read from the store and then loaded into the output register. No new byte
// is accepted until the current byte's store walk is done.
// A stalled receiver holds the output register and the emission waits; the
// next byte is accepted while the row's final word still waits to be taken.
// Reset (synchronous, rst high) clears the control registers and the per-word
// valid bits, so the store reads as transparent without a clearing pass.
module run_length_cel_decoder_unit #(
  parameter int unsigned MAX_WIDTH       = 256,
  parameter int unsigned PIXELS_PER_WORD = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlc_pkg::CFG_DATA_W-1:0]   cfg_data,
  rlc_chunk_if.sink                        chunk,
  rlc_pixel_if.source                      pixels
);
  import rlc_pkg::*;

  localparam int unsigned PPW    = PIXELS_PER_WORD;
  localparam int unsigned SHIFT  = $clog2(PPW);
  localparam int unsigned WORDS  = (MAX_WIDTH + PPW - 1) / PPW;
  localparam int unsigned IDX_W  = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int unsigned DATA_W = PPW * COLOR_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_EMIT = 5'b01000,
    S_LOAD = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [POS_W-1:0]   cel_width;
  logic [ROW_W-1:0]   cel_height;
  logic [COLOR_W-1:0] transparent_color;
  logic               mirror_enable;

  // Row state
  logic [POS_W-1:0]   run_position;
  logic [ROW_W-1:0]   row_counter;
  logic               overflow_seen;

  // Current run / emission
  logic [COLOR_W-1:0] run_color;
  logic [POS_W-1:0]   run_lo;
  logic [POS_W-1:0]   run_lim;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   last_idx;

  // Output register
  logic               out_v;
  logic [WORD_W-1:0]  out_word;
  logic [VCNT_W-1:0]  out_cnt;
  logic [ROW_W-1:0]   out_row;
  logic               out_last_word;
  logic               out_last_row;
  logic               out_ovf;

  // Store port
  logic               mem_wr_en;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_idx;
  logic [DATA_W-1:0]  mem_wr_data;
  logic [DATA_W-1:0]  mem_rd_data;
  logic               mem_clear;

  // Combinational helpers
  logic               acc;
  logic               byte_zero;
  logic [POS_W-1:0]   w;
  logic [4:0]         run_len;
  logic [POS_W:0]     run_end;
  logic               end_past;
  logic [POS_W-1:0]   lim;
  logic               has_px;
  logic [POS_W-1:0]   lo_col;
  logic [POS_W-1:0]   hi_col;
  logic [IDX_W-1:0]   next_idx;
  logic               at_last;
  logic [POS_W-1:0]   base_col;
  logic [POS_W-1:0]   rem_cols;
  logic               last_row;
  logic               out_take;
  logic               emit_go;
  logic               row_done;
  logic [WORD_W-1:0]  emit_word;
  logic [VCNT_W-1:0]  emit_cnt;

  assign w = (cel_width > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : cel_width;

  // Request handshakes
  assign chunk.ready = (state == S_IDLE);
  assign acc         = chunk.valid && chunk.ready;
  assign byte_zero   = (chunk.chunk_byte == '0);
  assign out_take    = out_v && pixels.ready;

  // Decode the run against the current position and width
  assign run_len  = {chunk.chunk_byte[3:0], 1'b0};
  assign run_end  = {1'b0, run_position} + (POS_W+1)'(run_len);
  assign end_past = (run_end > {1'b0, w});
  assign lim      = end_past ? w : run_end[POS_W-1:0];
  assign has_px   = (lim > run_position);
  assign lo_col   = mirror_enable ? (w - lim) : run_position;
  assign hi_col   = mirror_enable ? (w - 9'd1 - run_position) : (lim - 9'd1);

  assign next_idx = cur_idx + IDX_W'(1);
  assign at_last  = (cur_idx == last_idx);
  assign base_col = POS_W'(cur_idx) << SHIFT;
  assign rem_cols = w - base_col;
  assign last_row = ({1'b0, row_counter} + 9'd1) >= {1'b0, cel_height};
  assign emit_go  = (state == S_EMIT) && (!out_v || pixels.ready);
  assign row_done = (state == S_LOAD) && at_last;

  // Merge the run's color into the word just read
  always_comb begin
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] x;
    mem_wr_data = mem_rd_data;
    for (int unsigned j = 0; j < PPW; j++) begin
      c = base_col | POS_W'(j);
      x = mirror_enable ? (w - 9'd1 - c) : c;
      if (c < w && x >= run_lo && x < run_lim) begin
        mem_wr_data[j*COLOR_W +: COLOR_W] = run_color;
      end
    end
  end

  // Shape the emitted word: slots past the width read as zero
  always_comb begin
    logic [POS_W-1:0] c;
    emit_word = '0;
    for (int unsigned j = 0; j < PPW; j++) begin
      c = base_col | POS_W'(j);
      if (c < w) begin
        emit_word[j*COLOR_W +: COLOR_W] = mem_rd_data[j*COLOR_W +: COLOR_W];
      end
    end
    emit_cnt = (rem_cols >= POS_W'(PPW)) ? VCNT_W'(PPW) : VCNT_W'(rem_cols);
  end

  // Store access control
  always_comb begin
    mem_wr_en  = (state == S_WR);
    mem_rd_en  = (state == S_RD) || ((state == S_WR) && !at_last) || emit_go;
    mem_rd_idx = (state == S_WR) ? next_idx : cur_idx;
    mem_clear  = (cfg_we && cfg_reg_t'(cfg_index) == REG_TRANSPARENT) || row_done;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (byte_zero) begin
            state_next = S_EMIT;
          end else if (has_px) begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        if (at_last) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = at_last ? S_IDLE : S_EMIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cel_width         <= '0;
      cel_height        <= '0;
      transparent_color <= '0;
      mirror_enable     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CEL_WIDTH:   cel_width         <= cfg_data[POS_W-1:0];
        REG_CEL_HEIGHT:  cel_height        <= cfg_data[ROW_W-1:0];
        REG_TRANSPARENT: transparent_color <= cfg_data[COLOR_W-1:0];
        REG_MIRROR:      mirror_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Row state: advance on runs; a row end clears it and bumps the row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run_position  <= '0;
      row_counter   <= '0;
      overflow_seen <= 1'b0;
    end else if (acc && !byte_zero) begin
      run_position <= (run_end > (POS_W+1)'(POS_MAX)) ? POS_MAX : run_end[POS_W-1:0];
      if (run_len != '0 && end_past) begin
        overflow_seen <= 1'b1;
      end
    end else if (row_done) begin
      run_position  <= '0;
      overflow_seen <= 1'b0;
      row_counter   <= last_row ? '0 : (row_counter + ROW_W'(1));
    end
  end

  // Run bounds and word walk
  always_ff @(posedge clk) begin
    if (acc) begin
      run_color <= chunk.chunk_byte[7:4];
      run_lo    <= run_position;
      run_lim   <= lim;
      if (byte_zero) begin
        cur_idx  <= '0;
        last_idx <= (w == '0) ? '0 : IDX_W'((w - 9'd1) >> SHIFT);
      end else begin
        cur_idx  <= IDX_W'(lo_col >> SHIFT);
        last_idx <= IDX_W'(hi_col >> SHIFT);
      end
    end else if ((state == S_WR && !at_last) || (state == S_LOAD && !at_last)) begin
      cur_idx <= next_idx;
    end
  end

  // Output register: load one word, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == S_LOAD) begin
      out_v <= 1'b1;
    end else if (out_take) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      out_word      <= emit_word;
      out_cnt       <= emit_cnt;
      out_row       <= row_counter;
      out_last_word <= at_last;
      out_last_row  <= last_row;
      out_ovf       <= overflow_seen;
    end
  end

  assign pixels.valid             = out_v;
  assign pixels.pixel_word        = out_word;
  assign pixels.pixel_valid_count = out_cnt;
  assign pixels.row_number        = out_row;
  assign pixels.row_last_word     = out_last_word;
  assign pixels.cel_last_row      = out_last_row;
  assign pixels.row_overflow      = out_ovf;

  rlc_row_store #(
    .DEPTH (WORDS),
    .PPW   (PPW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear      (mem_clear),
    .fill_color (transparent_color),
    .wr_en      (mem_wr_en),
    .wr_idx     (cur_idx),
    .wr_data    (mem_wr_data),
    .rd_en      (mem_rd_en),
    .rd_idx     (mem_rd_idx),
    .rd_data    (mem_rd_data)
  );

  // The output register is free whenever a store word lands for emission
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !out_v)
    else $error("emission word would overwrite a pending request");

  // A read never targets the word being written in the same cycle
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_idx != cur_idx))
    else $error("store read overlaps write of the same word");

  // A row end always starts the emission
  a_zero_emits: assert property (@(posedge clk) disable iff (rst)
    (acc && byte_zero) |=> (state == S_EMIT))
    else $error("row end byte did not start emission");

  // Run writes stay inside the walked word range
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (cur_idx <= last_idx))
    else $error("store write outside the run's word range");

  // The final word of a row leaves the run position and overflow flag cleared
  a_row_reset: assert property (@(posedge clk) disable iff (rst)
    row_done |=> (run_position == '0 && !overflow_seen))
    else $error("row state not cleared after the final word");

endmodule

@@ sv/rlc_row_store.sv @@
module rlc_row_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PPW   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  clear,
  input  logic [rlc_pkg::COLOR_W-1:0]           fill_color,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_idx,
  input  logic [PPW*rlc_pkg::COLOR_W-1:0]       wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_idx,
  output logic [PPW*rlc_pkg::COLOR_W-1:0]       rd_data
);
  import rlc_pkg::*;

  localparam int unsigned DATA_W = PPW * COLOR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  row_valid;
  logic [DATA_W-1:0] rd_raw;
  logic              rd_hit;

  // Word memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_idx];
      rd_hit <= row_valid[rd_idx];
    end
  end

  // Track written words; a clear drops them all back to the fill color
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_idx] <= 1'b1;
    end
  end

  // Substitute the fill color for words not written since the last clear
  assign rd_data = rd_hit ? rd_raw : {PPW{fill_color}};

endmodule
